@@ src/hdlcdf_pkg.sv @@
package hdlcdf_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 10;
   localparam int CRC_W  = 16;

   localparam logic [CRC_W-1:0]  CRC_INIT     = 16'hFFFF;
   localparam logic [CRC_W-1:0]  CRC_POLY     = 16'h8408;
   localparam logic [CRC_W-1:0]  CRC_GOOD     = 16'hF0B8;
   localparam logic [BYTE_W-1:0] FLAG_PATTERN = 8'h7E;
   localparam logic [2:0]        STUFF_RUN    = 3'd5;
   localparam logic [2:0]        ONES_MAX     = 3'd7;

   // result event codes
   localparam logic [1:0] EV_DATA = 2'd0;
   localparam logic [1:0] EV_END  = 2'd1;
   localparam logic [1:0] EV_DROP = 2'd2;

   // csr register indexes
   localparam logic [1:0] CSR_MIN_FRAME = 2'd0;
   localparam logic [1:0] CSR_FCS_MIN   = 2'd1;
   localparam logic [1:0] CSR_MAX_FRAME = 2'd2;

   localparam logic [LEN_W-1:0] MIN_FRAME_RESET = 10'd15;
   localparam logic [LEN_W-1:0] FCS_MIN_RESET   = 10'd16;
   localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 10'd330;

   typedef struct packed {
      logic [LEN_W-1:0] min_frame_bytes;
      logic [LEN_W-1:0] fcs_min_bytes;
      logic [LEN_W-1:0] max_frame_bytes;
   } cfg_type;

   typedef struct packed {
      logic [1:0]        event_kind;
      logic [BYTE_W-1:0] data_byte;
      logic [LEN_W-1:0]  byte_position;
      logic [LEN_W-1:0]  frame_length;
      logic              fcs_good;
   } rsp_type;

   // CRC-16/X.25 update over one byte, LSB first
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < BYTE_W; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ src/hdlcdf_csr.sv @@
module hdlcdf_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [hdlcdf_pkg::LEN_W-1:0] csr_data,
   output hdlcdf_pkg::cfg_type        cfg
);
   import hdlcdf_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MIN_FRAME: cfg_in.min_frame_bytes = csr_data;
            CSR_FCS_MIN:   cfg_in.fcs_min_bytes   = csr_data;
            CSR_MAX_FRAME: cfg_in.max_frame_bytes = csr_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_frame_bytes <= MIN_FRAME_RESET;
         cfg_ff.fcs_min_bytes   <= FCS_MIN_RESET;
         cfg_ff.max_frame_bytes <= MAX_FRAME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/hdlcdf_engine.sv @@
module hdlcdf_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic                line_bit,
   input  hdlcdf_pkg::cfg_type cfg,
   output logic                res_valid,
   output hdlcdf_pkg::rsp_type res
);
   import hdlcdf_pkg::*;

   logic [BYTE_W-1:0] flag_shift_ff, flag_shift_in;
   logic [2:0]        ones_run_ff, ones_run_in;
   logic [BYTE_W-1:0] asm_byte_ff, asm_byte_in;
   logic [2:0]        bit_count_ff, bit_count_in;
   logic [LEN_W-1:0]  byte_count_ff, byte_count_in;
   logic              receiving_ff, receiving_in;
   logic [CRC_W-1:0]  crc_ff, crc_in;

   logic [BYTE_W-1:0] shift_next;
   logic [BYTE_W-1:0] asm_next;
   logic [2:0]        ones_inc;

   always_comb begin
      shift_next    = {line_bit, flag_shift_ff[BYTE_W-1:1]};
      asm_next      = {line_bit, asm_byte_ff[BYTE_W-1:1]};
      ones_inc      = ones_run_ff + 3'd1;

      flag_shift_in = flag_shift_ff;
      ones_run_in   = ones_run_ff;
      asm_byte_in   = asm_byte_ff;
      bit_count_in  = bit_count_ff;
      byte_count_in = byte_count_ff;
      receiving_in  = receiving_ff;
      crc_in        = crc_ff;
      res_valid     = 1'b0;
      res           = '0;

      if (step_en) begin
         flag_shift_in = shift_next;
         if (shift_next == FLAG_PATTERN) begin
            // flag: close the open frame and start over
            flag_shift_in = '0;
            ones_run_in   = '0;
            asm_byte_in   = '0;
            bit_count_in  = '0;
            byte_count_in = '0;
            crc_in        = CRC_INIT;
            if (receiving_ff && byte_count_ff >= cfg.min_frame_bytes) begin
               receiving_in     = 1'b0;
               res_valid        = 1'b1;
               res.event_kind   = EV_END;
               res.frame_length = byte_count_ff;
               res.fcs_good     = (byte_count_ff >= cfg.fcs_min_bytes) &&
                                  (crc_ff == CRC_GOOD);
            end else begin
               receiving_in = 1'b1;
               if (receiving_ff && byte_count_ff != '0) begin
                  res_valid        = 1'b1;
                  res.event_kind   = EV_DROP;
                  res.frame_length = byte_count_ff;
               end
            end
         end else if (!receiving_ff) begin
            if (line_bit) begin
               if (ones_run_ff != ONES_MAX) ones_run_in = ones_inc;
            end else begin
               ones_run_in = '0;
            end
         end else if (ones_run_ff == STUFF_RUN && !line_bit) begin
            // drop the stuffed zero
            ones_run_in = '0;
         end else if (line_bit && ones_inc == ONES_MAX) begin
            // seventh one: abort
            ones_run_in  = ones_inc;
            receiving_in = 1'b0;
            if (byte_count_ff != '0) begin
               res_valid        = 1'b1;
               res.event_kind   = EV_DROP;
               res.frame_length = byte_count_ff;
            end
         end else begin
            ones_run_in  = line_bit ? ones_inc : 3'd0;
            asm_byte_in  = asm_next;
            bit_count_in = bit_count_ff + 3'd1;
            if (bit_count_ff == 3'd7) begin
               asm_byte_in = '0;
               if (byte_count_ff < cfg.max_frame_bytes) begin
                  crc_in            = crc_byte(crc_ff, asm_next);
                  byte_count_in     = byte_count_ff + 10'd1;
                  res_valid         = 1'b1;
                  res.event_kind    = EV_DATA;
                  res.data_byte     = asm_next;
                  res.byte_position = byte_count_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_shift_ff <= '0;
         ones_run_ff   <= '0;
         asm_byte_ff   <= '0;
         bit_count_ff  <= '0;
         byte_count_ff <= '0;
         receiving_ff  <= 1'b0;
         crc_ff        <= CRC_INIT;
      end else begin
         flag_shift_ff <= flag_shift_in;
         ones_run_ff   <= ones_run_in;
         asm_byte_ff   <= asm_byte_in;
         bit_count_ff  <= bit_count_in;
         byte_count_ff <= byte_count_in;
         receiving_ff  <= receiving_in;
         crc_ff        <= crc_in;
      end
   end

endmodule

@@ src/hdlc_bit_deframer_with_fcs_core.sv @@
// Path: an accepted bit waits in the input bit register until the output is free; then its
//    result is offered on rsp_ (two register stages: input bit, result register).
// Throughput: one line bit per cycle while rsp_stall does not hold a pending result.
// Reset (synchronous, active high): both stages empty, frame state cleared, CRC at 0xFFFF,
//    registers at min_frame_bytes 15, fcs_min_bytes 16, max_frame_bytes 330.
module hdlc_bit_deframer_with_fcs_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_line_bit,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_event_kind,
   output logic [hdlcdf_pkg::BYTE_W-1:0] rsp_data_byte,
   output logic [hdlcdf_pkg::LEN_W-1:0]  rsp_byte_position,
   output logic [hdlcdf_pkg::LEN_W-1:0]  rsp_frame_length,
   output logic                         rsp_fcs_good,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [1:0]                   csr_index,
   input  logic [hdlcdf_pkg::LEN_W-1:0]  csr_data
);
   import hdlcdf_pkg::*;

   cfg_type cfg;
   rsp_type res;
   rsp_type rsp_ff;
   logic    res_valid;

   logic in_valid_ff, in_valid_in;
   logic in_bit_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;
   logic advance;
   logic req_take;

   hdlcdf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hdlcdf_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .line_bit  (in_bit_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      rsp_valid_in = rsp_valid_ff;
      if (advance && res_valid) rsp_valid_in = 1'b1;
      else if (out_free) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold payloads unless a new transaction loads them
   always_ff @(posedge clock) begin
      if (req_take) in_bit_ff <= req_line_bit;
      if (advance && res_valid) rsp_ff <= res;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_kind    = rsp_ff.event_kind;
   assign rsp_data_byte     = rsp_ff.data_byte;
   assign rsp_byte_position = rsp_ff.byte_position;
   assign rsp_frame_length  = rsp_ff.frame_length;
   assign rsp_fcs_good      = rsp_ff.fcs_good;

endmodule

@@ src/hdlcdf_checker.sv @@
module hdlcdf_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_event_kind,
   input logic [7:0] rsp_data_byte,
   input logic [9:0] rsp_byte_position,
   input logic [9:0] rsp_frame_length,
   input logic       rsp_fcs_good
);
   import hdlcdf_pkg::*;

   // a stalled transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_kind) &&
      $stable(rsp_data_byte) && $stable(rsp_byte_position) &&
      $stable(rsp_frame_length) && $stable(rsp_fcs_good))
      else $error("rsp transaction changed while stalled");

   a_data_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_DATA |-> rsp_frame_length == '0 && !rsp_fcs_good)
      else $error("data byte carries frame end fields");

   a_end_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind != EV_DATA |->
      rsp_data_byte == '0 && rsp_byte_position == '0)
      else $error("frame event carries byte fields");

   a_drop_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_DROP |-> !rsp_fcs_good && rsp_frame_length != '0)
      else $error("drop event with good fcs or empty length");

endmodule

bind hdlc_bit_deframer_with_fcs_core hdlcdf_checker u_hdlcdf_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_event_kind    (rsp_event_kind),
   .rsp_data_byte     (rsp_data_byte),
   .rsp_byte_position (rsp_byte_position),
   .rsp_frame_length  (rsp_frame_length),
   .rsp_fcs_good      (rsp_fcs_good)
);
